// File: hw/rtl/snapshot_file_record_parser_unit_defines.svh
// assertion macros for the snapshot file record parser
// expects clk and rst_n in the scope of each use
`ifndef SNAPSHOT_FILE_RECORD_PARSER_UNIT_DEFINES_SVH
`define SNAPSHOT_FILE_RECORD_PARSER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define SFRP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfrp assertion failed");
`define SFRP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfrp assertion failed");
`else
`define SFRP_ASSERT_NOW(lbl, ante, cons)
`define SFRP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/sfrp_pkg.sv
// shared types, codes and constant tables for the snapshot file record parser
// no dependencies
package sfrp_pkg;

  typedef enum logic [2:0] {
    EV_KEY       = 3'd0,
    EV_VAL       = 3'd1,
    EV_ENTRY_END = 3'd2,
    EV_FILE_END  = 3'd3,
    EV_ERROR     = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_SHORT  = 3'd1,
    ERR_HEADER = 3'd2,
    ERR_TRUNC  = 3'd3,
    ERR_LENGTH = 3'd4,
    ERR_LZF    = 3'd5,
    ERR_ENC    = 3'd6,
    ERR_TYPE   = 3'd7
  } err_t;

  typedef enum logic [8:0] {
    PH_HEADER = 9'b000000001,
    PH_OPCODE = 9'b000000010,
    PH_LEN    = 9'b000000100,
    PH_LENX   = 9'b000001000,
    PH_STR    = 9'b000010000,
    PH_INT    = 9'b000100000,
    PH_EXP    = 9'b001000000,
    PH_TYPE   = 9'b010000000,
    PH_DONE   = 9'b100000000
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_AUX_KEY = 3'd0,
    ROLE_AUX_VAL = 3'd1,
    ROLE_SELECT  = 3'd2,
    ROLE_RESIZE1 = 3'd3,
    ROLE_RESIZE2 = 3'd4,
    ROLE_KEY     = 3'd5,
    ROLE_VALUE   = 3'd6
  } role_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_TEXT = 5'b00010,
    ST_CONV = 5'b00100,
    ST_END  = 5'b01000,
    ST_TAIL = 5'b10000
  } ctl_state_t;

  localparam logic [7:0] OP_AUX     = 8'hFA;
  localparam logic [7:0] OP_RESIZE  = 8'hFB;
  localparam logic [7:0] OP_EXP_MS  = 8'hFC;
  localparam logic [7:0] OP_EXP_S   = 8'hFD;
  localparam logic [7:0] OP_SELECT  = 8'hFE;
  localparam logic [7:0] OP_EOF     = 8'hFF;
  localparam logic [7:0] TYPE_STR   = 8'h00;
  localparam logic [7:0] LEN_32     = 8'h80;
  localparam logic [7:0] LEN_64     = 8'h81;
  localparam logic [5:0] LEN_LOW    = 6'h3F;
  localparam logic [3:0] HDR_LEN    = 4'd9;
  localparam logic [3:0] DEC_TOP    = 4'd9;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_MINUS  = 8'h2D;
  localparam int unsigned MS_PER_S  = 1000;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  text;
    logic        hx;
    logic [63:0] ms;
    err_t        code;
  } result_t;

  typedef struct packed {
    logic       step;
    logic       emit;
    logic       last;
    logic       conv_adv;
    ctl_state_t sel;
  } cmd_t;

  typedef struct packed {
    logic new_text;
    logic new_conv;
    logic new_end;
    logic new_tail;
    logic p_conv;
    logic p_end;
    logic p_tail;
    logic conv_out;
    logic conv_done;
  } sts_t;

  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'd0:    r = 8'h52;
      4'd1:    r = 8'h45;
      4'd2:    r = 8'h44;
      4'd3:    r = 8'h49;
      4'd4:    r = 8'h53;
      4'd5:    r = 8'h30;
      4'd6:    r = 8'h30;
      4'd7:    r = 8'h31;
      default: r = 8'h31;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pow10(input logic [3:0] k);
    logic [31:0] r;
    unique case (k)
      4'd0:    r = 32'd1;
      4'd1:    r = 32'd10;
      4'd2:    r = 32'd100;
      4'd3:    r = 32'd1000;
      4'd4:    r = 32'd10000;
      4'd5:    r = 32'd100000;
      4'd6:    r = 32'd1000000;
      4'd7:    r = 32'd10000000;
      4'd8:    r = 32'd100000000;
      default: r = 32'd1000000000;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/sfrp_ctrl.sv
// sequencing state machine: accepts bytes and walks the results of each byte
// depends on sfrp_pkg
module sfrp_ctrl import sfrp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic slot_free,
  input  sts_t sts,
  output cmd_t cmd
);

  ctl_state_t state_r, state_nxt;
  logic       rdy;

  function automatic ctl_state_t pick(input logic t, input logic c, input logic e,
                                      input logic l);
    ctl_state_t s;
    if (t) s = ST_TEXT;
    else if (c) s = ST_CONV;
    else if (e) s = ST_END;
    else if (l) s = ST_TAIL;
    else s = ST_IDLE;
    return s;
  endfunction

  always_comb begin
    cmd          = '0;
    cmd.sel      = state_r;
    state_nxt    = state_r;
    rdy          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        rdy = 1'b1;
      end
      ST_TEXT: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = !(sts.p_conv || sts.p_end || sts.p_tail);
          state_nxt = pick(1'b0, sts.p_conv, sts.p_end, sts.p_tail);
          rdy       = cmd.last;
        end
      end
      ST_CONV: begin
        if (!sts.conv_out) begin
          cmd.conv_adv = 1'b1;
        end else if (slot_free) begin
          cmd.emit     = 1'b1;
          cmd.conv_adv = 1'b1;
          if (sts.conv_done) begin
            cmd.last  = !(sts.p_end || sts.p_tail);
            state_nxt = pick(1'b0, 1'b0, sts.p_end, sts.p_tail);
            rdy       = cmd.last;
          end
        end
      end
      ST_END: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = !sts.p_tail;
          state_nxt = pick(1'b0, 1'b0, 1'b0, sts.p_tail);
          rdy       = cmd.last;
        end
      end
      ST_TAIL: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
          rdy       = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    cmd.step = rdy && in_valid;
    if (cmd.step) begin
      state_nxt = pick(sts.new_text, sts.new_conv, sts.new_end, sts.new_tail);
    end
  end

  assign in_ready = rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/sfrp_datapath.sv
// parser registers, byte decode and decimal conversion of integer strings
// depends on sfrp_pkg
module sfrp_datapath import sfrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  logic       in_eof,
  input  cmd_t       cmd,
  output sts_t       sts,
  output result_t    res
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hdr_idx_r, hdr_idx_nxt;
  logic        hdr_bad_r, hdr_bad_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] word_r, word_nxt;
  logic [63:0] rem_r, rem_nxt;
  role_t       role_r, role_nxt;
  logic        exp_on_r, exp_on_nxt;
  logic [63:0] exp_r, exp_nxt;
  logic        err_r, err_nxt;

  // pending results of the last accepted byte
  logic        p_text_ev_r, p_text_ev_nxt;
  logic [7:0]  p_text_r, p_text_nxt;
  logic        p_conv_r, p_conv_nxt;
  logic        p_conv_ev_r, p_conv_ev_nxt;
  logic        p_end_r, p_end_nxt;
  logic        p_end_hx_r, p_end_hx_nxt;
  logic [63:0] p_end_ms_r, p_end_ms_nxt;
  logic        p_tail_r, p_tail_nxt;
  event_t      p_tail_ev_r, p_tail_ev_nxt;
  err_t        p_tail_code_r, p_tail_code_nxt;
  logic        new_text;

  // decimal conversion
  logic [31:0] mag_r, mag_nxt;
  logic [3:0]  dk_r, dk_nxt;
  logic [3:0]  dig_r, dig_nxt;
  logic        started_r, started_nxt;
  logic        neg_r, neg_nxt;

  logic [31:0] pw;
  logic        ge;

  always_comb begin
    logic        do_ld, ld_enc, do_int, do_sd, neg;
    logic [63:0] ld_val;
    logic [41:0] sec_ms;
    logic [31:0] sx;

    phase_nxt       = phase_r;
    hdr_idx_nxt     = hdr_idx_r;
    hdr_bad_nxt     = hdr_bad_r;
    cnt_nxt         = cnt_r;
    word_nxt        = word_r;
    rem_nxt         = rem_r;
    role_nxt        = role_r;
    exp_on_nxt      = exp_on_r;
    exp_nxt         = exp_r;
    err_nxt         = err_r;
    new_text        = 1'b0;
    p_text_ev_nxt   = p_text_ev_r;
    p_text_nxt      = p_text_r;
    p_conv_nxt      = p_conv_r;
    p_conv_ev_nxt   = p_conv_ev_r;
    p_end_nxt       = p_end_r;
    p_end_hx_nxt    = p_end_hx_r;
    p_end_ms_nxt    = p_end_ms_r;
    p_tail_nxt      = p_tail_r;
    p_tail_ev_nxt   = p_tail_ev_r;
    p_tail_code_nxt = p_tail_code_r;
    mag_nxt         = mag_r;
    dk_nxt          = dk_r;
    dig_nxt         = dig_r;
    started_nxt     = started_r;
    neg_nxt         = neg_r;
    do_ld           = 1'b0;
    ld_enc          = 1'b0;
    ld_val          = '0;
    do_int          = 1'b0;
    do_sd           = 1'b0;
    neg             = 1'b0;
    sec_ms          = '0;
    sx              = '0;

    // conversion steps, one compare and subtract per cycle while no digit waits on the output
    if (cmd.conv_adv) begin
      if (neg_r) begin
        neg_nxt = 1'b0;
      end else if (ge) begin
        mag_nxt = mag_r - pw;
        dig_nxt = dig_r + 4'd1;
      end else begin
        started_nxt = started_r || (dig_r != 4'd0);
        dig_nxt     = 4'd0;
        if (dk_r != 4'd0) dk_nxt = dk_r - 4'd1;
      end
    end

    if (cmd.step) begin
      p_conv_nxt = 1'b0;
      p_end_nxt  = 1'b0;
      p_tail_nxt = 1'b0;
      if (!err_r && phase_r != PH_DONE) begin
        unique case (phase_r)
          PH_HEADER: begin
            if (in_byte != magic_byte(hdr_idx_r)) hdr_bad_nxt = 1'b1;
            hdr_idx_nxt = hdr_idx_r + 4'd1;
            if (hdr_idx_nxt >= HDR_LEN) begin
              if (hdr_bad_nxt) begin
                err_nxt = 1'b1; p_tail_nxt = 1'b1;
                p_tail_ev_nxt = EV_ERROR; p_tail_code_nxt = ERR_HEADER;
              end else begin
                phase_nxt = PH_OPCODE;
              end
            end
          end
          PH_OPCODE: begin
            if (in_byte == OP_EOF) begin
              p_tail_nxt = 1'b1; p_tail_ev_nxt = EV_FILE_END;
              p_tail_code_nxt = ERR_NONE;
              phase_nxt = PH_DONE;
            end else if (in_byte == OP_AUX) begin
              role_nxt = ROLE_AUX_KEY; phase_nxt = PH_LEN;
            end else if (in_byte == OP_SELECT) begin
              role_nxt = ROLE_SELECT; phase_nxt = PH_LEN;
            end else if (in_byte == OP_RESIZE) begin
              role_nxt = ROLE_RESIZE1; phase_nxt = PH_LEN;
            end else if (in_byte == OP_EXP_MS || in_byte == OP_EXP_S) begin
              rem_nxt   = (in_byte == OP_EXP_MS) ? 64'd8 : 64'd4;
              cnt_nxt   = 4'd0;
              exp_nxt   = '0;
              phase_nxt = PH_EXP;
            end else if (in_byte == TYPE_STR) begin
              role_nxt = ROLE_KEY; phase_nxt = PH_LEN;
            end else begin
              err_nxt = 1'b1; p_tail_nxt = 1'b1;
              p_tail_ev_nxt = EV_ERROR; p_tail_code_nxt = ERR_TYPE;
            end
          end
          PH_TYPE: begin
            if (in_byte == TYPE_STR) begin
              role_nxt = ROLE_KEY; phase_nxt = PH_LEN;
            end else begin
              err_nxt = 1'b1; p_tail_nxt = 1'b1;
              p_tail_ev_nxt = EV_ERROR; p_tail_code_nxt = ERR_TYPE;
            end
          end
          PH_EXP: begin
            exp_nxt = exp_r | (64'(in_byte) << {cnt_r[2:0], 3'b000});
            cnt_nxt = cnt_r + 4'd1;
            if ({60'd0, cnt_nxt} >= rem_r) begin
              if (rem_r == 64'd4) begin
                sec_ms  = 42'(exp_nxt[31:0]) * 42'(MS_PER_S);
                exp_nxt = {22'd0, sec_ms};
              end
              exp_on_nxt = 1'b1;
              cnt_nxt    = 4'd0;
              phase_nxt  = PH_TYPE;
            end
          end
          PH_LEN: begin
            if (in_byte[7:6] == 2'b00) begin
              do_ld = 1'b1; ld_val = {58'd0, in_byte[5:0] & LEN_LOW};
            end else if (in_byte[7:6] == 2'b01) begin
              word_nxt = {58'd0, in_byte[5:0] & LEN_LOW};
              cnt_nxt = 4'd1; phase_nxt = PH_LENX;
            end else if (in_byte == LEN_32 || in_byte == LEN_64) begin
              word_nxt = '0;
              cnt_nxt = (in_byte == LEN_32) ? 4'd4 : 4'd8;
              phase_nxt = PH_LENX;
            end else if (in_byte[7:6] == 2'b11) begin
              do_ld = 1'b1; ld_enc = 1'b1; ld_val = {58'd0, in_byte[5:0] & LEN_LOW};
            end else begin
              err_nxt = 1'b1; p_tail_nxt = 1'b1;
              p_tail_ev_nxt = EV_ERROR; p_tail_code_nxt = ERR_LENGTH;
            end
          end
          PH_LENX: begin
            word_nxt = {word_r[55:0], in_byte};
            if (cnt_r != 4'd0) cnt_nxt = cnt_r - 4'd1;
            if (cnt_nxt == 4'd0) begin
              do_ld = 1'b1; ld_val = word_nxt;
            end
          end
          PH_STR: begin
            if (role_r == ROLE_KEY || role_r == ROLE_VALUE) begin
              new_text      = 1'b1;
              p_text_ev_nxt = (role_r == ROLE_VALUE);
              p_text_nxt    = in_byte;
            end
            rem_nxt = rem_r - 64'd1;
            if (rem_nxt == 64'd0) do_sd = 1'b1;
          end
          PH_INT: begin
            word_nxt = word_r | (64'(in_byte) << {cnt_r[1:0], 3'b000});
            cnt_nxt  = cnt_r + 4'd1;
            if ({60'd0, cnt_nxt} >= rem_r) begin
              cnt_nxt = 4'd0;
              do_int  = 1'b1;
            end
          end
          default: begin
          end
        endcase

        // length prefix complete
        if (do_ld) begin
          if (role_r == ROLE_SELECT || role_r == ROLE_RESIZE2) begin
            phase_nxt = PH_OPCODE;
          end else if (role_r == ROLE_RESIZE1) begin
            role_nxt = ROLE_RESIZE2; phase_nxt = PH_LEN;
          end else if (!ld_enc) begin
            if (ld_val == 64'd0) begin
              do_sd = 1'b1;
            end else begin
              rem_nxt = ld_val; phase_nxt = PH_STR;
            end
          end else if (ld_val <= 64'd2) begin
            rem_nxt   = (ld_val == 64'd0) ? 64'd1 : (ld_val == 64'd1) ? 64'd2 : 64'd4;
            cnt_nxt   = 4'd0;
            word_nxt  = '0;
            phase_nxt = PH_INT;
          end else begin
            err_nxt = 1'b1; p_tail_nxt = 1'b1; p_tail_ev_nxt = EV_ERROR;
            p_tail_code_nxt = (ld_val == 64'd3) ? ERR_LZF : ERR_ENC;
          end
        end

        // integer string complete: sign extend, and for a key or value start the conversion
        if (do_int) begin
          if (rem_r == 64'd1) sx = {{24{word_nxt[7]}}, word_nxt[7:0]};
          else if (rem_r == 64'd2) sx = {{16{word_nxt[15]}}, word_nxt[15:0]};
          else sx = word_nxt[31:0];
          neg = sx[31];
          if (role_r == ROLE_KEY || role_r == ROLE_VALUE) begin
            p_conv_nxt    = 1'b1;
            p_conv_ev_nxt = (role_r == ROLE_VALUE);
            mag_nxt       = neg ? (32'd0 - sx) : sx;
            dk_nxt        = DEC_TOP;
            dig_nxt       = 4'd0;
            started_nxt   = 1'b0;
            neg_nxt       = neg;
          end
          do_sd = 1'b1;
        end

        // string complete
        if (do_sd) begin
          unique case (role_r)
            ROLE_AUX_KEY: begin
              role_nxt = ROLE_AUX_VAL; phase_nxt = PH_LEN;
            end
            ROLE_KEY: begin
              role_nxt = ROLE_VALUE; phase_nxt = PH_LEN;
            end
            ROLE_VALUE: begin
              p_end_nxt    = 1'b1;
              p_end_hx_nxt = exp_on_r;
              p_end_ms_nxt = exp_on_r ? exp_nxt : 64'd0;
              exp_on_nxt   = 1'b0;
              exp_nxt      = '0;
              phase_nxt    = PH_OPCODE;
            end
            default: begin
              phase_nxt = PH_OPCODE;
            end
          endcase
        end

        // end of file handling
        if (in_eof && !err_nxt && phase_nxt != PH_DONE) begin
          p_tail_nxt = 1'b1;
          if (phase_nxt == PH_HEADER) begin
            err_nxt = 1'b1; p_tail_ev_nxt = EV_ERROR; p_tail_code_nxt = ERR_SHORT;
          end else if (phase_nxt == PH_OPCODE) begin
            p_tail_ev_nxt = EV_FILE_END; p_tail_code_nxt = ERR_NONE;
          end else begin
            err_nxt = 1'b1; p_tail_ev_nxt = EV_ERROR; p_tail_code_nxt = ERR_TRUNC;
          end
        end
        if (in_eof && !err_nxt) phase_nxt = PH_DONE;
      end
    end
  end

  assign pw = pow10(dk_r);
  assign ge = (mag_r >= pw);

  always_comb begin
    sts           = '0;
    sts.new_text  = new_text;
    sts.new_conv  = cmd.step && p_conv_nxt;
    sts.new_end   = cmd.step && p_end_nxt;
    sts.new_tail  = cmd.step && p_tail_nxt;
    sts.p_conv    = p_conv_r;
    sts.p_end     = p_end_r;
    sts.p_tail    = p_tail_r;
    sts.conv_out  = neg_r || (!ge && (started_r || dig_r != 4'd0 || dk_r == 4'd0));
    sts.conv_done = !neg_r && !ge && (dk_r == 4'd0);
  end

  always_comb begin
    res = '0;
    unique case (cmd.sel)
      ST_TEXT: begin
        res.ev   = p_text_ev_r ? EV_VAL : EV_KEY;
        res.text = p_text_r;
      end
      ST_CONV: begin
        res.ev   = p_conv_ev_r ? EV_VAL : EV_KEY;
        res.text = neg_r ? CHR_MINUS : (CHR_ZERO | {4'd0, dig_r});
      end
      ST_END: begin
        res.ev = EV_ENTRY_END;
        res.hx = p_end_hx_r;
        res.ms = p_end_ms_r;
      end
      ST_TAIL: begin
        res.ev   = p_tail_ev_r;
        res.code = p_tail_code_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_idx_r <= '0;
      hdr_bad_r <= 1'b0;
      cnt_r     <= '0;
      word_r    <= '0;
      rem_r     <= '0;
      role_r    <= ROLE_AUX_KEY;
      exp_on_r  <= 1'b0;
      exp_r     <= '0;
      err_r     <= 1'b0;
      p_conv_r  <= 1'b0;
      p_end_r   <= 1'b0;
      p_tail_r  <= 1'b0;
      neg_r     <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      hdr_bad_r <= hdr_bad_nxt;
      cnt_r     <= cnt_nxt;
      word_r    <= word_nxt;
      rem_r     <= rem_nxt;
      role_r    <= role_nxt;
      exp_on_r  <= exp_on_nxt;
      exp_r     <= exp_nxt;
      err_r     <= err_nxt;
      p_conv_r  <= p_conv_nxt;
      p_end_r   <= p_end_nxt;
      p_tail_r  <= p_tail_nxt;
      neg_r     <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_text_ev_r   <= p_text_ev_nxt;
    p_text_r      <= p_text_nxt;
    p_conv_ev_r   <= p_conv_ev_nxt;
    p_end_hx_r    <= p_end_hx_nxt;
    p_end_ms_r    <= p_end_ms_nxt;
    p_tail_ev_r   <= p_tail_ev_nxt;
    p_tail_code_r <= p_tail_code_nxt;
    mag_r         <= mag_nxt;
    dk_r          <= dk_nxt;
    dig_r         <= dig_nxt;
    started_r     <= started_nxt;
  end

endmodule

// File: hw/rtl/snapshot_file_record_parser_unit.sv
// top level of the snapshot file record parser: ports, output register, checks
// depends on sfrp_pkg, sfrp_ctrl, sfrp_datapath and the defines header
//
// Parses a key-value snapshot file presented one byte per item on the in_
// stream (in_tlast marks the final byte) and produces key bytes, value bytes,
// entry-end items with the expiry, a file-end item or a single error item on
// the out_ stream. A byte that yields no result or one result is taken every
// cycle while the output keeps draining. A byte that yields several results
// occupies the block until its results are loaded one after another; an
// integer-encoded string additionally runs a decimal conversion by repeated
// compare-and-subtract against powers of ten. One output register parts the
// two sides, so a new byte is taken in the cycle its predecessor's last
// result is loaded. After an error or the end of the file all further bytes
// are taken and dropped until reset.
`include "snapshot_file_record_parser_unit_defines.svh"
module snapshot_file_record_parser_unit import sfrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte [7:0]
  input  logic        in_tlast,   // end_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // text_byte [7:0], has_expiry [8], expiry_time [72:9],
                                  // error_code [75:73], zero fill [79:76]
  output logic [2:0]  out_tuser,  // event_res [2:0]
  output logic        out_tlast   // last
);

  cmd_t    cmd;
  sts_t    sts;
  result_t res;
  logic    slot_free;

  // single output register
  logic    out_valid_r;
  result_t out_res_r;
  logic    out_last_r;

  assign slot_free = !out_valid_r || out_tready;

  sfrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .slot_free (slot_free),
    .sts       (sts),
    .cmd       (cmd)
  );

  sfrp_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_byte (in_tdata),
    .in_eof  (in_tlast),
    .cmd     (cmd),
    .sts     (sts),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_res_r  <= res;
      out_last_r <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r.code, out_res_r.ms, out_res_r.hx, out_res_r.text};
  assign out_tuser  = out_res_r.ev;
  assign out_tlast  = out_last_r;

  // file end and error always close the results of their byte
  `SFRP_ASSERT_NOW(a_tail_last, out_valid_r && (out_res_r.ev == EV_FILE_END ||
    out_res_r.ev == EV_ERROR), out_last_r)
  // error code only on error items, and never zero there
  `SFRP_ASSERT_NOW(a_code_err, out_valid_r, (out_res_r.ev == EV_ERROR) ==
    (out_res_r.code != ERR_NONE))
  // text byte only on key and value items
  `SFRP_ASSERT_NOW(a_text_zero, out_valid_r && out_res_r.ev != EV_KEY &&
    out_res_r.ev != EV_VAL, out_res_r.text == 8'd0)
  // a loaded result is never overwritten before it is taken
  `SFRP_ASSERT_NOW(a_no_overrun, cmd.emit, slot_free)

endmodule

// File: tb/sv/snapshot_file_record_parser_checker.sv
// result checker for the snapshot file record parser: watches both streams,
// predicts the result items of each accepted byte and compares them in order
// depends on sfrp_pkg for the event, error, phase and role codes and the byte constants
module snapshot_file_record_parser_checker import sfrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);

  typedef struct {
    event_t      ev;
    logic [7:0]  text;
    logic        hx;
    logic [63:0] ms;
    err_t        code;
    logic        last;
  } parse_result_t;

  localparam logic [7:0] FILE_MAGIC [9] = '{8'h52, 8'h45, 8'h44, 8'h49, 8'h53,
                                            8'h30, 8'h30, 8'h31, 8'h31};

  parse_result_t expected_results[$];

  phase_t      phase;
  role_t       role;
  logic [3:0]  hdr_idx;
  logic        hdr_bad;
  logic [3:0]  byte_cnt;
  logic [63:0] word;
  logic [63:0] remaining;
  logic        exp_present;
  logic [63:0] exp_value;
  logic        err_latched;

  task automatic add_result(event_t ev, logic [7:0] text, logic hx, logic [63:0] ms,
                            err_t code);
    parse_result_t r;
    r.ev = ev; r.text = text; r.hx = hx; r.ms = ms; r.code = code; r.last = 1'b0;
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic raise_error(err_t code);
    err_latched = 1'b1;
    add_result(EV_ERROR, 8'h00, 1'b0, 64'd0, code);
  endtask

  task automatic finish_string();
    case (role)
      ROLE_AUX_KEY: begin
        role = ROLE_AUX_VAL;
        phase = PH_LEN;
      end
      ROLE_KEY: begin
        role = ROLE_VALUE;
        phase = PH_LEN;
      end
      ROLE_VALUE: begin
        add_result(EV_ENTRY_END, 8'h00, exp_present, exp_present ? exp_value : 64'd0,
                   ERR_NONE);
        exp_present = 1'b0;
        exp_value = 64'd0;
        phase = PH_OPCODE;
      end
      default: phase = PH_OPCODE;
    endcase
  endtask

  task automatic finish_length(logic [63:0] value, logic encoded);
    if (role == ROLE_SELECT || role == ROLE_RESIZE2) begin
      phase = PH_OPCODE;
    end else if (role == ROLE_RESIZE1) begin
      role = ROLE_RESIZE2;
      phase = PH_LEN;
    end else if (!encoded) begin
      if (value == 0) begin
        finish_string();
      end else begin
        remaining = value;
        phase = PH_STR;
      end
    end else if (value <= 2) begin
      // int8, int16, int32 take 1, 2, 4 bytes
      remaining = (value == 0) ? 64'd1 : (value == 1) ? 64'd2 : 64'd4;
      byte_cnt = 0;
      word = 0;
      phase = PH_INT;
    end else if (value == 3) begin
      raise_error(ERR_LZF);
    end else begin
      raise_error(ERR_ENC);
    end
  endtask

  task automatic emit_decimal();
    logic [63:0] mag;
    logic [7:0]  digs [20];
    int          nd;
    int          bits;
    logic        neg;
    event_t      ev;
    bits = int'(remaining) * 8;
    neg = word[bits-1];
    mag = neg ? ((64'd1 << bits) - word) : word;
    nd = 0;
    do begin
      digs[nd] = 8'h30 + 8'(mag % 10);
      nd++;
      mag = mag / 10;
    end while (mag != 0);
    if (role == ROLE_KEY || role == ROLE_VALUE) begin
      ev = (role == ROLE_KEY) ? EV_KEY : EV_VAL;
      if (neg) add_result(ev, 8'h2D, 1'b0, 64'd0, ERR_NONE);
      while (nd > 0) begin
        nd--;
        add_result(ev, digs[nd], 1'b0, 64'd0, ERR_NONE);
      end
    end
    finish_string();
  endtask

  task automatic take_byte(logic [7:0] b);
    case (phase)
      PH_HEADER: begin
        if (b != FILE_MAGIC[hdr_idx]) hdr_bad = 1'b1;
        hdr_idx++;
        if (hdr_idx >= 9) begin
          if (hdr_bad) raise_error(ERR_HEADER);
          else phase = PH_OPCODE;
        end
      end
      PH_OPCODE, PH_TYPE: begin
        if (b == TYPE_STR) begin
          role = ROLE_KEY;
          phase = PH_LEN;
        end else if (phase == PH_TYPE) begin
          raise_error(ERR_TYPE);
        end else if (b == OP_EOF) begin
          add_result(EV_FILE_END, 8'h00, 1'b0, 64'd0, ERR_NONE);
          phase = PH_DONE;
        end else if (b == OP_AUX) begin
          role = ROLE_AUX_KEY;
          phase = PH_LEN;
        end else if (b == OP_SELECT) begin
          role = ROLE_SELECT;
          phase = PH_LEN;
        end else if (b == OP_RESIZE) begin
          role = ROLE_RESIZE1;
          phase = PH_LEN;
        end else if (b == OP_EXP_MS || b == OP_EXP_S) begin
          remaining = (b == OP_EXP_MS) ? 64'd8 : 64'd4;
          byte_cnt = 0;
          exp_value = 0;
          phase = PH_EXP;
        end else begin
          raise_error(ERR_TYPE);
        end
      end
      PH_EXP: begin
        exp_value |= 64'(b) << (byte_cnt[2:0] * 8);
        byte_cnt++;
        if (byte_cnt >= remaining) begin
          if (remaining == 4) exp_value = exp_value * 1000;
          exp_present = 1'b1;
          byte_cnt = 0;
          phase = PH_TYPE;
        end
      end
      PH_LEN: begin
        if (b[7:6] == 2'b00) begin
          finish_length(64'(b[5:0]), 1'b0);
        end else if (b[7:6] == 2'b01) begin
          word = 64'(b[5:0]);
          byte_cnt = 1;
          phase = PH_LENX;
        end else if (b == LEN_32 || b == LEN_64) begin
          word = 0;
          byte_cnt = (b == LEN_32) ? 4'd4 : 4'd8;
          phase = PH_LENX;
        end else if (b[7:6] == 2'b11) begin
          finish_length(64'(b[5:0]), 1'b1);
        end else begin
          raise_error(ERR_LENGTH);
        end
      end
      PH_LENX: begin
        word = {word[55:0], b};
        if (byte_cnt > 0) byte_cnt--;
        if (byte_cnt == 0) finish_length(word, 1'b0);
      end
      PH_STR: begin
        if (role == ROLE_KEY || role == ROLE_VALUE)
          add_result((role == ROLE_KEY) ? EV_KEY : EV_VAL, b, 1'b0, 64'd0, ERR_NONE);
        remaining--;
        if (remaining == 0) finish_string();
      end
      PH_INT: begin
        word |= 64'(b) << (byte_cnt[1:0] * 8);
        byte_cnt++;
        if (byte_cnt >= remaining) begin
          byte_cnt = 0;
          emit_decimal();
        end
      end
      default: ;
    endcase
  endtask

  // predicts every result item of one accepted file byte
  task automatic predict_byte(logic [7:0] b, logic eof);
    int n_prior;
    n_prior = expected_results.size();
    if (err_latched || phase == PH_DONE) return;
    take_byte(b);
    if (eof && !err_latched && phase != PH_DONE) begin
      if (phase == PH_HEADER) begin
        raise_error(ERR_SHORT);
      end else if (phase == PH_OPCODE) begin
        add_result(EV_FILE_END, 8'h00, 1'b0, 64'd0, ERR_NONE);
      end else begin
        raise_error(ERR_TRUNC);
      end
    end
    if (eof) phase = PH_DONE;
    if (expected_results.size() > n_prior)
      expected_results[expected_results.size()-1].last = 1'b1;
  endtask

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    parse_result_t e;
    if (!rst_n) begin
      phase = PH_HEADER;
      role = ROLE_AUX_KEY;
      hdr_idx = 0;
      hdr_bad = 1'b0;
      byte_cnt = 0;
      word = 0;
      remaining = 0;
      exp_present = 1'b0;
      exp_value = 0;
      err_latched = 1'b0;
      fail_count = 0;
      results_seen = 0;
      pending = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: event %0d text %0h", out_tuser,
                 out_tdata[7:0]);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          check_field("event_res", 64'(e.ev), 64'(out_tuser));
          check_field("text_byte", 64'(e.text), 64'(out_tdata[7:0]));
          check_field("has_expiry", 64'(e.hx), 64'(out_tdata[8]));
          check_field("expiry_time", e.ms, out_tdata[72:9]);
          check_field("error_code", 64'(e.code), 64'(out_tdata[75:73]));
          check_field("last", 64'(e.last), 64'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) predict_byte(in_tdata, in_tlast);
      pending = expected_results.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// top of the snapshot file record parser testbench: clock, reset, file stimulus,
// output back-pressure, watchdog and verdict
// depends on sfrp_pkg, snapshot_file_record_parser_unit and the checker module
module tb_top import sfrp_pkg::*;;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          pending;
  int          results_seen;

  localparam int IDLE_LIMIT = 5000;

  // file bytes as {end_of_file, data_byte}
  logic [8:0] file_bytes[$];
  int         n_entries, n_ints, n_meta;
  string      ending;

  snapshot_file_record_parser_unit u_dut (.*);
  snapshot_file_record_parser_checker u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic put(logic [7:0] b);
    file_bytes.insert(file_bytes.size(), {1'b0, b});
  endtask

  // length prefix in a random legal form, or a forced one (0 6-bit, 1 14-bit,
  // 2 32-bit big-endian, 3 64-bit big-endian)
  task automatic put_len(logic [63:0] n, int form = -1);
    int f;
    f = form;
    if (f < 0) begin
      f = $urandom_range(0, 9);
      f = (f < 6) ? 0 : (f < 8) ? 1 : (f == 8) ? 2 : 3;
    end
    if (f == 0 && n >= 64) f = 1;
    if (f == 1 && n >= 16384) f = 2;
    if (f == 2 && n >= 64'h1_0000_0000) f = 3;
    case (f)
      0: put({2'b00, n[5:0]});
      1: begin
        put({2'b01, n[13:8]});
        put(n[7:0]);
      end
      2: begin
        put(LEN_32);
        for (int i = 3; i >= 0; i--) put(n[i*8 +: 8]);
      end
      default: begin
        put(LEN_64);
        for (int i = 7; i >= 0; i--) put(n[i*8 +: 8]);
      end
    endcase
  endtask

  task automatic put_text(int n, int form = -1);
    put_len(64'(n), form);
    repeat (n) put(8'($urandom));
  endtask

  // integer-encoded string, kind 0 int8, 1 int16, 2 int32, little-endian
  task automatic put_int(int kind, logic [31:0] v);
    put({2'b11, 6'(kind)});
    for (int i = 0; i < (1 << kind); i++) put(v[i*8 +: 8]);
    n_ints++;
  endtask

  task automatic put_rand_string();
    int r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      put_text($urandom_range(0, 6));
    end else if (r < 60) begin
      put_text($urandom_range(60, 200));
    end else begin
      v = $urandom;
      case ($urandom_range(0, 5))
        0: v = 32'h8000_0000;
        1: v = 32'h7FFF_FFFF;
        2: v = 32'hFFFF_FF80;
        3: v = 32'h0000_0000;
        default: ;
      endcase
      put_int($urandom_range(0, 2), v);
    end
  endtask

  task automatic put_entry(int exp_kind);
    if (exp_kind == 1) begin
      put(OP_EXP_MS);
      repeat (8) put(8'($urandom));
    end else if (exp_kind == 2) begin
      put(OP_EXP_S);
      repeat (4) put(8'($urandom));
    end
    put(TYPE_STR);
    put_rand_string();
    put_rand_string();
    n_entries++;
  endtask

  // select-db and resize-db take any length byte, an encoded one too
  task automatic put_db_len();
    if ($urandom_range(0, 4) == 0) put({2'b11, 6'($urandom)});
    else put_len({$urandom, $urandom} >> $urandom_range(0, 63));
  endtask

  task automatic build_file();
    int r;
    // header
    put(8'h52); put(8'h45); put(8'h44); put(8'h49); put(8'h53);
    put(8'h30); put(8'h30); put(8'h31); put(8'h31);
    // directed records: every opcode but the end one, every length form, integer extremes
    put(OP_SELECT); put(8'h00);
    put(OP_SELECT); put({2'b00, LEN_LOW});
    put(OP_RESIZE); put_len(64'hFFFF_FFFF_FFFF_FFFF, 3); put(8'hC5);
    put(OP_AUX); put_text(1); put_int(0, 32'hFF);
    put(TYPE_STR); put_text(0); put_text(0, 3);
    n_entries++;
    put(OP_EXP_MS); repeat (8) put(8'hFF);
    put(TYPE_STR); put_int(2, 32'h8000_0000); put_int(2, 32'h7FFF_FFFF);
    n_entries++;
    put(OP_EXP_S); repeat (4) put(8'hFF);
    put(TYPE_STR); put_int(1, 32'h8000); put_int(0, 32'h80);
    n_entries++;
    put(OP_EXP_MS); repeat (8) put(8'h00);
    put(TYPE_STR); put_text(64, 1); put_text(3, 2);
    n_entries++;
    put(OP_EXP_S); repeat (4) put(8'h00);
    put(TYPE_STR); put_int(0, 32'h0); put_int(1, 32'h7FFF);
    n_entries++;
    put(OP_AUX); put_int(2, 32'hFFFF_FFFF); put_text(2, 3);
    n_meta += 5;
    // random records, mostly entries
    while (file_bytes.size() < 380) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        put_entry($urandom_range(0, 2));
      end else begin
        n_meta++;
        if (r < 75) begin
          put(OP_AUX);
          put_rand_string();
          put_rand_string();
        end else if (r < 88) begin
          put(OP_SELECT);
          put_db_len();
        end else begin
          put(OP_RESIZE);
          put_db_len();
          put_db_len();
        end
      end
    end
    // one way to end the file per run
    case ($urandom_range(0, 8))
      0: begin ending = "end opcode"; put(OP_EOF); end
      1: begin ending = "end opcode on last byte"; put(OP_EOF);
         file_bytes[$][8] = 1'b1; end
      2: begin ending = "last byte closing an entry"; put_entry(0);
         file_bytes[$][8] = 1'b1; end
      3: begin ending = "truncated expiry"; put(OP_EXP_MS); repeat (3) put(8'h5A);
         file_bytes[$][8] = 1'b1; end
      4: begin ending = "bad length prefix"; put(TYPE_STR);
         put({2'b10, 6'($urandom_range(2, 63))}); end
      5: begin ending = "lzf string"; put(OP_AUX); put(8'hC3); end
      6: begin ending = "bad string encoding"; put(TYPE_STR);
         put({2'b11, 6'($urandom_range(4, 63))}); end
      7: begin ending = "bad type after expiry"; put(OP_EXP_S); repeat (4) put(8'h11);
         put(8'($urandom_range(1, 255))); end
      default: begin ending = "bad opcode"; put(8'($urandom_range(1, 249))); end
    endcase
    // trailing bytes must be dropped silently
    repeat (8) file_bytes.insert(file_bytes.size(), 9'($urandom));
  endtask

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output back-pressure: runs of ready and stall, some of them long
  initial begin
    int run;
    logic rdy;
    run = 0;
    rdy = 1'b1;
    forever begin
      @(posedge clk);
      if (run == 0) begin
        rdy = ($urandom_range(0, 2) != 0);
        run = rdy ? $urandom_range(1, ($urandom_range(0, 4) == 0) ? 200 : 8) : rand_gap() + 1;
      end
      out_tready <= rdy;
      run--;
    end
  end

  // watchdog on cycles without any accepted item
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    n_entries = 0;
    n_ints = 0;
    n_meta = 0;
    build_file();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (file_bytes[i]) begin
      gap = rand_gap();
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= file_bytes[i][7:0];
      in_tlast <= file_bytes[i][8];
      // handshake is judged on the level held before the edge
      forever begin
        @(negedge clk);
        if (in_tready) break;
      end
      @(posedge clk);
    end
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("run: %0d file bytes, %0d entries (%0d integer strings), %0d metadata records",
             file_bytes.size(), n_entries, n_ints, n_meta);
    $display("run: %0d result items checked, file ending: %s", results_seen, ending);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
